[design/kpe_pkg.sv]
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types and constants for the scalar-covariance position estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kpe_pkg;

    // CORDIC datapath width: Q30 values plus growth and sign
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // atan(2^-i), full circle = 2^32
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IW  = 5;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Configuration register indexes
    localparam logic [2:0] CFG_START_X    = 3'd0;
    localparam logic [2:0] CFG_START_Y    = 3'd1;
    localparam logic [2:0] CFG_INIT_COV   = 3'd2;
    localparam logic [2:0] CFG_PROC_NOISE = 3'd3;
    localparam logic [2:0] CFG_SENS_NOISE = 3'd4;

    localparam logic [31:0] RST_INIT_COV   = 32'd6553600;
    localparam logic [31:0] RST_PROC_NOISE = 32'd65536;
    localparam logic [31:0] RST_SENS_NOISE = 32'd327680;

    // Sequencer states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RUN  = 8'b0000_0010,
        S_MC   = 8'b0000_0100,
        S_MS   = 8'b0000_1000,
        S_MX   = 8'b0001_0000,
        S_MY   = 8'b0010_0000,
        S_MP   = 8'b0100_0000,
        S_UPD  = 8'b1000_0000
    } t_state;

    // CORDIC status and result
    typedef struct packed {
        logic                       busy;
        logic signed [CORDIC_W-1:0] cos_v;
        logic signed [CORDIC_W-1:0] sin_v;
    } t_cordic_res;

endpackage

`default_nettype wire

[design/kalman_position_estimator.sv]
// ----------------------------------------------------------------------------
// kalman_position_estimator
// Scalar-covariance position filter: CORDIC, gain divider, shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: accept, then wait for the CORDIC and the divider, then the multiplier
// steps MC, MS, MX, MY, MP and the update step UPD, which registers the result.
// One item in flight; the next transfer is taken only after the result has been
// registered, and UPD waits while the output is stalled.
// Synchronous active-low reset loads the default registers and estimate.
`timescale 1ns / 1ps
`default_nettype none

module kalman_position_estimator #(
    parameter int FRAC_BITS       = 16,
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_commanded_x,
    input  wire logic signed [15:0] i_commanded_y,
    input  wire logic signed [19:0] i_odometry_distance,
    input  wire logic [15:0]        i_compass_heading,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_estimate_x,
    output logic signed [15:0]      o_estimate_y
);

    localparam int AW = kpe_pkg::CORDIC_W + 1;
    localparam int BW = (FRAC_BITS + 2 > 20) ? FRAC_BITS + 2 : 20;
    localparam int PW = AW + BW;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic signed [63:0] f_trunc(input logic signed [63:0] v,
                                                    input int unsigned n);
        logic signed [63:0] m;
        m = -v;
        return v[63] ? -(m >>> n) : (v >>> n);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)       r = 16'sh7FFF;
        else if (v < -64'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    kpe_pkg::t_state      r_state;
    kpe_pkg::t_cordic_res cordic_res;

    // configuration and filter state
    logic signed [15:0] r_start_x, r_start_y, n_start_x, n_start_y;
    logic [31:0]        r_init_cov, r_q, r_r, n_init_cov, n_q, n_r;
    logic               n_reload;
    logic signed [31:0] r_est_x, r_est_y;
    logic [31:0]        r_cov;

    // per-item registers
    logic signed [19:0]     r_d;
    logic signed [31:0]     r_px, r_py, r_mx, r_my, r_nx, r_ny;
    logic [31:0]            r_pp;
    logic                   r_sum_zero;
    logic [FRAC_BITS:0]     r_k;
    logic signed [PW-1:0]   r_prod;
    logic                   r_out_valid;
    logic signed [15:0]     r_out_x, r_out_y;

    logic                   in_xfer, out_free, start;
    logic [32:0]            pp_raw, sum;
    logic [31:0]            pp_sat;
    logic                   div_busy;
    logic [FRAC_BITS:0]     div_quot;
    logic signed [AW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [32:0]     diff_x, diff_y;

    assign o_in_stall = (r_state != kpe_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign start      = in_xfer;
    assign out_free   = !r_out_valid || !i_out_stall;

    // predicted covariance and gain divisor
    assign pp_raw = {1'b0, r_cov} + {1'b0, r_q};
    assign pp_sat = pp_raw[32] ? 32'hFFFF_FFFF : pp_raw[31:0];
    assign sum    = {1'b0, pp_sat} + {1'b0, r_r};

    kpe_cordic #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_angle (ANGLE_BITS'(i_compass_heading)),
        .o_res   (cordic_res)
    );

    kpe_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (pp_sat),
        .i_den   (sum),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // shared multiplier operand selection
    assign diff_x = {r_mx[31], r_mx} - {r_px[31], r_px};
    assign diff_y = {r_my[31], r_my} - {r_py[31], r_py};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            kpe_pkg::S_MC: begin
                mul_a = AW'(cordic_res.cos_v);
                mul_b = BW'(r_d);
            end
            kpe_pkg::S_MS: begin
                mul_a = AW'(cordic_res.sin_v);
                mul_b = BW'(r_d);
            end
            kpe_pkg::S_MX: begin
                mul_a = AW'(diff_x);
                mul_b = signed'(BW'(r_k));
            end
            kpe_pkg::S_MY: begin
                mul_a = AW'(diff_y);
                mul_b = signed'(BW'(r_k));
            end
            kpe_pkg::S_MP: begin
                mul_a = signed'(AW'(r_pp));
                mul_b = signed'(BW'(ONE - r_k));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpe_pkg::S_IDLE;
        end else begin
            case (r_state)
                kpe_pkg::S_IDLE: if (in_xfer) r_state <= kpe_pkg::S_RUN;
                kpe_pkg::S_RUN: begin
                    if (!cordic_res.busy && !div_busy) r_state <= kpe_pkg::S_MC;
                end
                kpe_pkg::S_MC:  r_state <= kpe_pkg::S_MS;
                kpe_pkg::S_MS:  r_state <= kpe_pkg::S_MX;
                kpe_pkg::S_MX:  r_state <= kpe_pkg::S_MY;
                kpe_pkg::S_MY:  r_state <= kpe_pkg::S_MP;
                kpe_pkg::S_MP:  r_state <= kpe_pkg::S_UPD;
                kpe_pkg::S_UPD: if (out_free) r_state <= kpe_pkg::S_IDLE;
                default:        r_state <= kpe_pkg::S_IDLE;
            endcase
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_d        <= i_odometry_distance;
            r_px       <= f_sat32(64'(i_commanded_x) <<< FRAC_BITS);
            r_py       <= f_sat32(64'(i_commanded_y) <<< FRAC_BITS);
            r_pp       <= pp_sat;
            r_sum_zero <= (sum == '0);
        end
        if (r_state == kpe_pkg::S_RUN) begin
            r_k <= r_sum_zero ? '0 : div_quot;
        end
        // covariance product is held while the result waits
        if (r_state != kpe_pkg::S_UPD) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            kpe_pkg::S_MS: r_mx <= f_sat32(64'(r_est_x) -
                                           f_trunc(64'(r_prod), 38 - FRAC_BITS));
            kpe_pkg::S_MX: r_my <= f_sat32(64'(r_est_y) -
                                           f_trunc(64'(r_prod), 38 - FRAC_BITS));
            kpe_pkg::S_MY: r_nx <= f_sat32(64'(r_px) + f_trunc(64'(r_prod), FRAC_BITS));
            kpe_pkg::S_MP: r_ny <= f_sat32(64'(r_py) + f_trunc(64'(r_prod), FRAC_BITS));
            default: begin
            end
        endcase
    end

    // configuration write decode
    always_comb begin
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_init_cov = r_init_cov;
        n_q        = r_q;
        n_r        = r_r;
        n_reload   = 1'b0;
        if (i_cfg_wr_en) begin
            n_reload = 1'b1;
            case (i_cfg_index)
                kpe_pkg::CFG_START_X:    n_start_x  = i_cfg_wdata[15:0];
                kpe_pkg::CFG_START_Y:    n_start_y  = i_cfg_wdata[15:0];
                kpe_pkg::CFG_INIT_COV:   n_init_cov = i_cfg_wdata;
                kpe_pkg::CFG_PROC_NOISE: n_q        = i_cfg_wdata;
                kpe_pkg::CFG_SENS_NOISE: n_r        = i_cfg_wdata;
                default:                 n_reload   = 1'b0;
            endcase
        end
    end

    // registers and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_init_cov <= kpe_pkg::RST_INIT_COV;
            r_q        <= kpe_pkg::RST_PROC_NOISE;
            r_r        <= kpe_pkg::RST_SENS_NOISE;
            r_est_x    <= '0;
            r_est_y    <= '0;
            r_cov      <= kpe_pkg::RST_INIT_COV;
        end else begin
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_init_cov <= n_init_cov;
            r_q        <= n_q;
            r_r        <= n_r;
            if (n_reload) begin
                r_est_x <= f_sat32(64'(n_start_x) <<< FRAC_BITS);
                r_est_y <= f_sat32(64'(n_start_y) <<< FRAC_BITS);
                r_cov   <= n_init_cov;
            end else if (r_state == kpe_pkg::S_UPD && out_free) begin
                r_est_x <= r_nx;
                r_est_y <= r_ny;
                r_cov   <= 32'(r_prod >>> FRAC_BITS);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == kpe_pkg::S_UPD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kpe_pkg::S_UPD && out_free) begin
            r_out_x <= f_sat16(f_trunc(64'(r_nx), FRAC_BITS));
            r_out_y <= f_sat16(f_trunc(64'(r_ny), FRAC_BITS));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_estimate_x = r_out_x;
    assign o_estimate_y = r_out_y;

`ifndef SYNTHESIS
    // no unit is left running while the block takes items
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpe_pkg::S_IDLE) |-> (!cordic_res.busy && !div_busy))
        else $error("shared unit busy while idle");

    // gain never above one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpe_pkg::S_MC) |-> (r_k <= ONE))
        else $error("gain above one");

    // updated covariance never exceeds the predicted one
    a_cov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpe_pkg::S_UPD && out_free && !n_reload) |=> (r_cov <= $past(r_pp)))
        else $error("covariance grew on update");
`endif

endmodule

`default_nettype wire

[design/kpe_cordic.sv]
// ----------------------------------------------------------------------------
// kpe_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpe_cordic #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output kpe_pkg::t_cordic_res       o_res
);

    localparam int ZW = ANGLE_BITS + 1;
    localparam int IW = $clog2(TRIG_ITERATIONS);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (ANGLE_BITS - 1);

    logic signed [kpe_pkg::CORDIC_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0]                r_z, n_z;
    logic signed [ZW-1:0]                z0, z1;
    logic signed [ZW-1:0]                a;
    logic                                r_neg, neg0;
    logic                                r_busy;
    logic [IW-1:0]                       r_iter;

    // fold angle into +-quarter circle
    always_comb begin
        z0   = signed'({i_angle[ANGLE_BITS-1], i_angle});
        z1   = z0;
        neg0 = 1'b0;
        if (z0 > QUARTER) begin
            z1   = z0 - HALF;
            neg0 = 1'b1;
        end else if (z0 < -QUARTER) begin
            z1   = z0 + HALF;
            neg0 = 1'b1;
        end
    end

    // one micro-rotation
    always_comb begin
        a = ZW'(kpe_pkg::ATAN_TAB[kpe_pkg::ATAN_IW'(r_iter)] >> (32 - ANGLE_BITS));
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_iter);
            n_y = r_y + (r_x >>> r_iter);
            n_z = r_z - a;
        end else begin
            n_x = r_x + (r_y >>> r_iter);
            n_y = r_y - (r_x >>> r_iter);
            n_z = r_z + a;
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == IW'(TRIG_ITERATIONS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= kpe_pkg::CORDIC_GAIN_Q30;
            r_y   <= '0;
            r_z   <= z1;
            r_neg <= neg0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_res.busy  = r_busy;
    assign o_res.cos_v = r_neg ? -r_x : r_x;
    assign o_res.sin_v = r_neg ? -r_y : r_y;

endmodule

`default_nettype wire

[design/kpe_divider.sv]
// ----------------------------------------------------------------------------
// kpe_divider
// Restoring divider for the gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpe_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [31:0]          i_num,
    input  wire logic [32:0]          i_den,
    output logic                      o_busy,
    output logic [FRAC_BITS:0]        o_quot
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [33:0]        r_rem;
    logic [32:0]        r_den;
    logic [FRAC_BITS:0] r_quot;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               ge;

    // numerator never exceeds the divisor, so the quotient fits in F+1 bits
    assign ge = (r_rem >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(FRAC_BITS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[FRAC_BITS-1:0], ge};
            r_rem  <= ge ? ((r_rem - {1'b0, r_den}) << 1) : (r_rem << 1);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
